// ----- rtl/rfir_pkg.sv -----
package rfir_pkg;

	// Operation codes carried by a command transaction
	typedef enum logic [1:0] {
		OP_ENQ = 2'd0,
		OP_DEQ = 2'd1,
		OP_FIR = 2'd2
	} op_t;

	// Field widths
	localparam int SAMPLE_W  = 16;
	localparam int WEIGHT_W  = 16;
	localparam int PROD_W    = 32;
	localparam int SUM_W     = 35;
	localparam int FILL_W    = 4;
	localparam int ACC_W     = 38;

	// Weight register file
	localparam int NUM_WEIGHTS = 8;
	localparam int WSEL_W      = 3;
	localparam int CFG_IDX_W   = 4;

	// Saturation bounds of the reported sum
	localparam logic signed [ACC_W-1:0] SUM_MAX = ACC_W'(64'sd17179869183);
	localparam logic signed [ACC_W-1:0] SUM_MIN = ACC_W'(-64'sd17179869184);

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [WEIGHT_W-1:0] weight_t;
	typedef logic signed [SUM_W-1:0]    sum_t;
	typedef weight_t [NUM_WEIGHTS-1:0]  weight_arr_t;

	// Control from the sequencer to the multiply-accumulate unit
	typedef struct packed {
		logic vld;
		logic clear;
	} mac_ctl_t;

endpackage

// ----- rtl/rfir_ifs.sv -----
// Command channel: one operation per transaction
interface rfir_in_if;
	logic                     valid;
	logic                     ready;
	logic [1:0]               operation;
	logic signed [15:0]       sample_in;

	modport source (output valid, operation, sample_in, input ready);
	modport sink   (input valid, operation, sample_in, output ready);
endinterface

// Response channel: one result per command
interface rfir_out_if;
	logic                     valid;
	logic                     ready;
	logic                     status;
	logic signed [15:0]       sample_out;
	logic signed [34:0]       fir_sum;
	logic [3:0]               fill_count;

	modport source (output valid, status, sample_out, fir_sum, fill_count, input ready);
	modport sink   (input valid, status, sample_out, fir_sum, fill_count, output ready);
endinterface

// Configuration write channel
interface rfir_cfg_if;
	logic                     valid;
	logic                     ready;
	logic [3:0]               index;
	logic [15:0]              data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/rfir_slot_ram.sv -----
module rfir_slot_ram #(
	parameter int DEPTH = 9,
	parameter int AW    = 4
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  rfir_pkg::sample_t     wdata,
	input  logic                  re,
	input  logic [AW-1:0]         raddr,
	output rfir_pkg::sample_t     rdata
);
	import rfir_pkg::*;

	sample_t mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/rfir_weights.sv -----
module rfir_weights (
	input  logic                  clk,
	input  logic                  arst_n,
	rfir_cfg_if.sink              cfg,
	output rfir_pkg::weight_arr_t weights
);
	import rfir_pkg::*;

	weight_arr_t weights_q;

	assign cfg.ready = 1'b1;
	assign weights   = weights_q;

	// Weight registers; writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weights_q <= '0;
		end else if (cfg.valid && (cfg.index < CFG_IDX_W'(NUM_WEIGHTS))) begin
			weights_q[cfg.index[WSEL_W-1:0]] <= cfg.data;
		end
	end

endmodule

// ----- rtl/rfir_mac.sv -----
module rfir_mac (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rfir_pkg::mac_ctl_t    ctl,
	input  rfir_pkg::sample_t     sample,
	input  rfir_pkg::weight_t     weight,
	output logic                  busy,
	output rfir_pkg::sum_t        sum
);
	import rfir_pkg::*;

	logic signed [PROD_W-1:0] prod_s2;
	logic                     vld_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [PROD_W-1:0] sample_ext;
	logic signed [PROD_W-1:0] weight_ext;
	logic signed [ACC_W-1:0]  acc_sat;

	assign sample_ext = PROD_W'(sample);
	assign weight_ext = PROD_W'(weight);
	assign busy       = vld_s2;

	// Product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= ctl.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.vld) begin
			prod_s2 <= sample_ext * weight_ext;
		end
	end

	// Accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.clear) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// Clamp to the reported range
	always_comb begin
		if (acc_q > SUM_MAX) begin
			acc_sat = SUM_MAX;
		end else if (acc_q < SUM_MIN) begin
			acc_sat = SUM_MIN;
		end else begin
			acc_sat = acc_q;
		end
	end

	assign sum = acc_sat[SUM_W-1:0];

endmodule

// ----- rtl/ring_fifo_with_fir.sv -----
// Ring FIFO of signed 16-bit samples with an FIR readout. Each command
// transaction enqueues a sample, dequeues the oldest one, or computes the
// weighted sum of all held samples (oldest times weight_0) when the FIFO is
// full; every command gives exactly one response with the fill count after
// it. Samples live in a single-port-read memory of CAPACITY+1 slots. An
// enqueue or a refused command goes idle to done, a dequeue via a read
// state, an FIR via run and drain: samples are read one per cycle
// through the memory read port into one multiply-accumulate unit with
// product and accumulate registers. A new command is taken while the
// last response waits in the output register; no clearing after reset.
module ring_fifo_with_fir #(
	parameter int CAPACITY = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	rfir_in_if.sink    cmd,
	rfir_out_if.source rsp,
	rfir_cfg_if.sink   cfg
);
	import rfir_pkg::*;

	localparam int SLOTS = CAPACITY + 1;
	localparam int IW    = $clog2(SLOTS);
	localparam int CW    = $clog2(CAPACITY + 1);
	localparam int KW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_DEQ   = 5'b00010,
		S_RUN   = 5'b00100,
		S_DRAIN = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t         state_q;
	logic [IW-1:0]  rd_q;
	logic [IW-1:0]  wr_q;
	logic [IW-1:0]  ptr_q;
	logic [CW-1:0]  count_q;
	logic [KW-1:0]  k_q;

	// Pending response
	logic           res_status_q;
	sample_t        res_sample_q;
	sum_t           res_sum_q;

	// Output register
	logic           out_valid_q;
	logic           status_q;
	sample_t        sample_q;
	sum_t           sum_q;
	logic [FILL_W-1:0] fill_q;

	// FIR pipeline
	logic           vld_s1;
	weight_t        wgt_s1;
	weight_arr_t    weights;
	weight_t        wgt_sel;
	logic [KW+2:0]  k_ext;
	mac_ctl_t       mac_ctl;
	logic           mac_busy;
	sum_t           mac_sum;

	// Memory ports
	logic           ram_we;
	logic           ram_re;
	logic [IW-1:0]  ram_raddr;
	sample_t        ram_rdata;

	logic           cmd_fire;
	logic           is_full;
	logic           is_empty;
	logic           out_free;
	logic [CW+3:0]  count_ext;

	function automatic logic [IW-1:0] advance(input logic [IW-1:0] i);
		advance = (i == IW'(SLOTS - 1)) ? '0 : i + 1'b1;
	endfunction

	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign is_full   = (count_q == CW'(CAPACITY));
	assign is_empty  = (count_q == '0);
	assign out_free  = !out_valid_q || rsp.ready;
	assign count_ext = {4'b0000, count_q};

	// Memory control: enqueue writes and dequeue reads only happen in idle,
	// FIR reads never overlap a write, so no forwarding is needed
	assign ram_we    = cmd_fire && (cmd.operation == OP_ENQ) && !is_full;
	assign ram_re    = (cmd_fire && (cmd.operation == OP_DEQ) && !is_empty)
	                   || (state_q == S_RUN);
	assign ram_raddr = (state_q == S_RUN) ? ptr_q : rd_q;

	rfir_slot_ram #(
		.DEPTH (SLOTS),
		.AW    (IW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_q),
		.wdata (cmd.sample_in),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	rfir_weights u_weights (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.weights (weights)
	);

	// Weight for the current tap; taps past the register list weigh zero
	assign k_ext = {3'b000, k_q};
	always_comb begin
		if (k_ext < (KW+3)'(NUM_WEIGHTS)) begin
			wgt_sel = weights[k_ext[WSEL_W-1:0]];
		end else begin
			wgt_sel = '0;
		end
	end

	// Weight and valid are registered so they line up with the read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= (state_q == S_RUN);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RUN) begin
			wgt_s1 <= wgt_sel;
		end
	end

	assign mac_ctl.vld   = vld_s1;
	assign mac_ctl.clear = cmd_fire && (cmd.operation == OP_FIR);

	rfir_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.sample (ram_rdata),
		.weight (wgt_s1),
		.busy   (mac_busy),
		.sum    (mac_sum)
	);

	// Sequencer and FIFO indices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rd_q    <= '0;
			wr_q    <= '0;
			ptr_q   <= '0;
			count_q <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_fire) begin
						case (cmd.operation)
							OP_ENQ: begin
								state_q <= S_DONE;
								if (!is_full) begin
									wr_q    <= advance(wr_q);
									count_q <= count_q + 1'b1;
								end
							end
							OP_DEQ: begin
								if (!is_empty) begin
									rd_q    <= advance(rd_q);
									count_q <= count_q - 1'b1;
									state_q <= S_DEQ;
								end else begin
									state_q <= S_DONE;
								end
							end
							OP_FIR: begin
								if (is_full) begin
									ptr_q   <= rd_q;
									k_q     <= '0;
									state_q <= S_RUN;
								end else begin
									state_q <= S_DONE;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_DEQ: begin
					state_q <= S_DONE;
				end
				S_RUN: begin
					ptr_q <= advance(ptr_q);
					k_q   <= k_q + 1'b1;
					if (k_q == KW'(CAPACITY - 1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!vld_s1 && !mac_busy) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Pending response payload
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			res_sample_q <= '0;
			res_sum_q    <= '0;
			case (cmd.operation)
				OP_ENQ:  res_status_q <= is_full;
				OP_DEQ:  res_status_q <= is_empty;
				OP_FIR:  res_status_q <= !is_full;
				default: res_status_q <= 1'b1;
			endcase
		end
		if (state_q == S_DEQ) begin
			res_sample_q <= ram_rdata;
		end
		if ((state_q == S_DRAIN) && !vld_s1 && !mac_busy) begin
			res_sum_q <= mac_sum;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			status_q <= res_status_q;
			sample_q <= res_sample_q;
			sum_q    <= res_sum_q;
			fill_q   <= count_ext[FILL_W-1:0];
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = status_q;
	assign rsp.sample_out = sample_q;
	assign rsp.fir_sum    = sum_q;
	assign rsp.fill_count = fill_q;

endmodule

// ----- sim/tb_ring_fifo_with_fir.sv -----
`timescale 1ns / 1ps

module tb_ring_fifo_with_fir;
	import rfir_pkg::*;

	localparam int CAP         = 8;
	localparam int SLOTS       = CAP + 1;
	localparam int LAT_CYCLES  = CAP + 8;
	localparam int HOLD_CYCLES = 80;
	localparam int WDOG_LIMIT  = 2000;
	localparam int PHASE_ITEMS = 100;
	localparam int NUM_PHASES  = 5;
	localparam int FLOOD_ITEMS = 24;
	localparam int MAX_PRINTS  = 40;
	localparam int DIR_ROWS    = 26;
	localparam int DIR_SPLIT   = 22;

	// Opcode 3 has no enum member: it must be refused
	localparam logic [1:0] OP_BAD = 2'd3;

	localparam logic ST_DONE    = 1'b0;
	localparam logic ST_REFUSED = 1'b1;

	localparam longint SUM_HI = 64'sd17179869183;
	localparam longint SUM_LO = -64'sd17179869184;

	typedef struct packed {
		logic              status;
		sample_t           sample_out;
		sum_t              fir_sum;
		logic [FILL_W-1:0] fill;
	} fifo_rsp_t;

	typedef struct packed {
		logic [1:0] op;
		sample_t    sample;
		logic       lit;
		fifo_rsp_t  want;
	} cmd_row_t;

	typedef enum {SMP_RANDOM, SMP_EXTREME, SMP_CONST} smp_mode_t;
	typedef enum {RX_ALWAYS, RX_COIN, RX_THIRD, RX_MOSTLY} rx_mode_t;
	typedef enum {WS_MAX, WS_MIN, WS_ALT, WS_RANDOM} wset_t;

	localparam fifo_rsp_t NO_WANT = '{ST_DONE, '0, '0, '0};
	localparam sample_t EXT_VALS [4] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};
	localparam wset_t WS_PLAN [NUM_PHASES] = '{WS_MAX, WS_ALT, WS_RANDOM, WS_MIN, WS_RANDOM};

	// Directed rows; lit marks a response typed in by hand
	localparam cmd_row_t DIR_TAB [DIR_ROWS] = '{
		'{OP_DEQ, 16'sh0000, 1'b1, '{ST_REFUSED, 16'sh0000, 35'sd0, 4'd0}},
		'{OP_FIR, 16'sh0000, 1'b1, '{ST_REFUSED, 16'sh0000, 35'sd0, 4'd0}},
		'{OP_BAD, 16'sh7fff, 1'b1, '{ST_REFUSED, 16'sh0000, 35'sd0, 4'd0}},
		'{OP_ENQ, 16'sh7fff, 1'b1, '{ST_DONE, 16'sh0000, 35'sd0, 4'd1}},
		'{OP_ENQ, 16'sh8000, 1'b1, '{ST_DONE, 16'sh0000, 35'sd0, 4'd2}},
		'{OP_DEQ, 16'sh0000, 1'b1, '{ST_DONE, 16'sh7fff, 35'sd0, 4'd1}},
		'{OP_DEQ, 16'sh0000, 1'b1, '{ST_DONE, 16'sh8000, 35'sd0, 4'd0}},
		'{OP_ENQ, 16'sh5555, 1'b0, NO_WANT},
		'{OP_ENQ, 16'shaaaa, 1'b0, NO_WANT},
		'{OP_ENQ, 16'sh0001, 1'b0, NO_WANT},
		'{OP_ENQ, 16'shffff, 1'b0, NO_WANT},
		'{OP_FIR, 16'sh0000, 1'b1, '{ST_REFUSED, 16'sh0000, 35'sd0, 4'd4}},
		'{OP_ENQ, 16'sh0000, 1'b0, NO_WANT},
		'{OP_ENQ, 16'sd12345, 1'b0, NO_WANT},
		'{OP_ENQ, -16'sd12345, 1'b0, NO_WANT},
		'{OP_ENQ, 16'sd100, 1'b0, NO_WANT},
		'{OP_ENQ, 16'sd7, 1'b1, '{ST_REFUSED, 16'sh0000, 35'sd0, 4'd8}},
		'{OP_FIR, 16'sh0000, 1'b1, '{ST_DONE, 16'sh0000, 35'sd0, 4'd8}},
		'{OP_DEQ, 16'sh0000, 1'b0, NO_WANT},
		'{OP_FIR, 16'sh0000, 1'b1, '{ST_REFUSED, 16'sh0000, 35'sd0, 4'd7}},
		'{OP_BAD, 16'shffff, 1'b1, '{ST_REFUSED, 16'sh0000, 35'sd0, 4'd7}},
		'{OP_ENQ, 16'sh8000, 1'b0, NO_WANT},
		// weights all at the negative extreme from here on
		'{OP_FIR, 16'sh0000, 1'b0, NO_WANT},
		'{OP_DEQ, 16'sh0000, 1'b0, NO_WANT},
		'{OP_ENQ, 16'sh7fff, 1'b0, NO_WANT},
		'{OP_FIR, 16'sh0000, 1'b0, NO_WANT}
	};

	logic clk = 1'b0;
	logic arst_n;

	rfir_in_if  cmd();
	rfir_out_if rsp();
	rfir_cfg_if cfg();

	ring_fifo_with_fir #(.CAPACITY(CAP)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	always #1 clk = ~clk;

	// Predictor state
	sample_t slot_mdl [SLOTS];
	int      rd_mdl;
	int      wr_mdl;
	weight_t wt_mdl [NUM_WEIGHTS];

	fifo_rsp_t rsp_expect_q [$];
	logic      cur_lit;
	fifo_rsp_t cur_want;

	int n_err;
	int n_cmd;
	int n_rsp;
	int n_fir_ok;
	int n_refused;
	int n_wsets;
	int idle_cyc;

	// Sender pacing and content
	int        burst_left;
	logic      fill_lean;
	smp_mode_t smp_mode;
	sample_t   smp_const;

	// Receiver pattern
	logic     hold_req;
	int       hold_cnt;
	rx_mode_t rx_mode;
	int       rx_left;
	int       rx_phase;

	// FIFO + FIR behavior for one command
	function automatic fifo_rsp_t fifo_fir_predict(logic [1:0] op, sample_t smp);
		fifo_rsp_t r;
		longint    acc;
		longint    w;
		int        p;
		r = '{ST_REFUSED, '0, '0, '0};
		case (op)
			OP_ENQ: begin
				if ((wr_mdl + 1) % SLOTS != rd_mdl) begin
					slot_mdl[wr_mdl] = smp;
					wr_mdl = (wr_mdl + 1) % SLOTS;
					r.status = ST_DONE;
				end
			end
			OP_DEQ: begin
				if (wr_mdl != rd_mdl) begin
					r.sample_out = slot_mdl[rd_mdl];
					rd_mdl = (rd_mdl + 1) % SLOTS;
					r.status = ST_DONE;
				end
			end
			OP_FIR: begin
				if ((wr_mdl + 1) % SLOTS == rd_mdl) begin
					acc = 0;
					p = rd_mdl;
					for (int k = 0; k < CAP; k++) begin
						w = (k < NUM_WEIGHTS) ? longint'(wt_mdl[k]) : 64'sd0;
						acc += longint'(slot_mdl[p]) * w;
						p = (p + 1) % SLOTS;
					end
					if (acc > SUM_HI) acc = SUM_HI;
					if (acc < SUM_LO) acc = SUM_LO;
					r.fir_sum = sum_t'(acc);
					r.status = ST_DONE;
				end
			end
			default: ;
		endcase
		r.fill = FILL_W'((wr_mdl + SLOTS - rd_mdl) % SLOTS);
		return r;
	endfunction

	task automatic report_mismatch(string what, logic signed [SUM_W-1:0] want,
			logic signed [SUM_W-1:0] got);
		n_err++;
		if (n_err <= MAX_PRINTS)
			$display("%0t mismatch on %s: expected %0d, got %0d", $time, what, want, got);
	endtask

	task automatic compare_rsp(fifo_rsp_t want, fifo_rsp_t got);
		if (got.status !== want.status) report_mismatch("status", want.status, got.status);
		if (got.sample_out !== want.sample_out)
			report_mismatch("sample_out", want.sample_out, got.sample_out);
		if (got.fir_sum !== want.fir_sum) report_mismatch("fir_sum", want.fir_sum, got.fir_sum);
		if (got.fill !== want.fill) report_mismatch("fill_count", want.fill, got.fill);
	endtask

	// Response check first, then prediction of a newly accepted command
	always @(posedge clk) begin
		fifo_rsp_t got;
		fifo_rsp_t pred;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.status, rsp.sample_out, rsp.fir_sum, rsp.fill_count};
				n_rsp++;
				if (rsp_expect_q.size() == 0)
					report_mismatch("response with nothing outstanding", '0, got.fill);
				else
					compare_rsp(rsp_expect_q.pop_front(), got);
			end
			if (cmd.valid && cmd.ready) begin
				pred = fifo_fir_predict(cmd.operation, cmd.sample_in);
				rsp_expect_q.push_back(cur_lit ? cur_want : pred);
				n_cmd++;
				if (pred.status == ST_REFUSED) n_refused++;
				else if (cmd.operation == OP_FIR) n_fir_ok++;
			end
		end
	end

	// Watchdog: cycles with no transaction on any channel
	always @(posedge clk) begin
		if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
			idle_cyc = 0;
		else
			idle_cyc++;
		if (idle_cyc >= WDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", WDOG_LIMIT);
			$display("tb: failure");
			$finish;
		end
	end

	// Receiver: long hold on request, else a pattern that changes now and then
	always @(posedge clk) begin
		if (hold_cnt != 0) begin
			hold_cnt--;
			rsp.ready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_cnt = HOLD_CYCLES - 1;
			rsp.ready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(10, 80);
			end else begin
				rx_left--;
			end
			rx_phase = (rx_phase + 1) % 3;
			case (rx_mode)
				RX_ALWAYS: rsp.ready <= 1'b1;
				RX_COIN:   rsp.ready <= ($urandom_range(0, 1) == 1);
				RX_THIRD:  rsp.ready <= (rx_phase == 0);
				default:   rsp.ready <= ($urandom_range(0, 6) != 0);
			endcase
		end
	end

	// Offer one command and wait for its transaction
	task automatic send_cmd(logic [1:0] op, sample_t smp, logic lit, fifo_rsp_t want);
		cmd.valid     <= 1'b1;
		cmd.operation <= op;
		cmd.sample_in <= smp;
		cur_lit       <= lit;
		cur_want      <= want;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
	endtask

	// Burst bookkeeping; a new burst also picks its operation mix and samples
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				cmd.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(0, 15);
			fill_lean  = ($urandom_range(0, 1) == 1);
			smp_mode   = smp_mode_t'($urandom_range(0, 2));
			smp_const  = EXT_VALS[$urandom_range(0, 1)];
		end
	endtask

	task automatic send_random();
		int         pick;
		logic [1:0] op;
		sample_t    smp;
		pick = $urandom_range(0, 99);
		if (fill_lean)
			op = (pick < 55) ? OP_ENQ : (pick < 80) ? OP_FIR : (pick < 96) ? OP_DEQ : OP_BAD;
		else
			op = (pick < 55) ? OP_DEQ : (pick < 75) ? OP_ENQ : (pick < 96) ? OP_FIR : OP_BAD;
		case (smp_mode)
			SMP_RANDOM:  smp = sample_t'($urandom);
			SMP_EXTREME: smp = EXT_VALS[$urandom_range(0, 3)];
			default:     smp = smp_const;
		endcase
		send_cmd(op, smp, 1'b0, NO_WANT);
	endtask

	// Let every outstanding response come back, then settle
	task automatic drain();
		cmd.valid <= 1'b0;
		@(posedge clk);
		while (rsp_expect_q.size() != 0) @(posedge clk);
		repeat (LAT_CYCLES) @(posedge clk);
	endtask

	// Write all weights, then one index past the list that must be ignored
	task automatic load_weights(wset_t kind);
		weight_t w;
		for (int k = 0; k < NUM_WEIGHTS; k++) begin
			case (kind)
				WS_MAX:  w = 16'sh7fff;
				WS_MIN:  w = 16'sh8000;
				WS_ALT:  w = (k % 2 == 0) ? 16'sh8000 : 16'sh7fff;
				default: w = weight_t'($urandom);
			endcase
			cfg.valid <= 1'b1;
			cfg.index <= CFG_IDX_W'(k);
			cfg.data  <= w;
			@(posedge clk);
			while (!cfg.ready) @(posedge clk);
			wt_mdl[k] = w;
		end
		cfg.index <= CFG_IDX_W'(NUM_WEIGHTS + $urandom_range(0, 7));
		cfg.data  <= 16'($urandom);
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		n_wsets++;
	endtask

	initial begin
		arst_n        = 1'b0;
		cmd.valid     = 1'b0;
		cmd.operation = OP_ENQ;
		cmd.sample_in = '0;
		rsp.ready     = 1'b0;
		cfg.valid     = 1'b0;
		cfg.index     = '0;
		cfg.data      = '0;
		cur_lit       = 1'b0;
		cur_want      = NO_WANT;
		rd_mdl        = 0;
		wr_mdl        = 0;
		foreach (slot_mdl[i]) slot_mdl[i] = '0;
		foreach (wt_mdl[i]) wt_mdl[i] = '0;
		n_err = 0; n_cmd = 0; n_rsp = 0; n_fir_ok = 0; n_refused = 0; n_wsets = 0;
		idle_cyc   = 0;
		burst_left = 0;
		fill_lean  = 1'b1;
		smp_mode   = SMP_RANDOM;
		smp_const  = EXT_VALS[0];
		hold_req   = 1'b0;
		hold_cnt   = 0;
		rx_mode    = RX_ALWAYS;
		rx_left    = 20;
		rx_phase   = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, reset weights first
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (i == DIR_SPLIT) begin
				drain();
				load_weights(WS_MIN);
			end
			send_cmd(DIR_TAB[i].op, DIR_TAB[i].sample, DIR_TAB[i].lit, DIR_TAB[i].want);
			pace();
		end

		// Random part, one weight set per phase
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain();
			load_weights(WS_PLAN[ph]);
			if (ph == 1) begin
				// receiver holds off while commands keep coming, so the input stalls
				hold_req = 1'b1;
				for (int n = 0; n < FLOOD_ITEMS; n++) send_random();
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_random();
				pace();
			end
		end
		drain();

		$display("summary: %0d commands, %0d responses, %0d FIR sums, %0d refused",
			n_cmd, n_rsp, n_fir_ok, n_refused);
		$display("summary: %0d weight sets loaded, %0d mismatches", n_wsets, n_err);
		if (n_err == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/rfir_pkg.sv
rtl/rfir_ifs.sv
rtl/rfir_slot_ram.sv
rtl/rfir_weights.sv
rtl/rfir_mac.sv
rtl/ring_fifo_with_fir.sv
sim/tb_ring_fifo_with_fir.sv
